// ----- hw/rtl/mso_pkg.sv -----
// Shared types, constants and helpers of the MP3 seek offset mapper.
`timescale 1ns / 1ps
package mso_pkg;

  localparam int TOC_DEPTH = 128;
  localparam int TOC_AW    = $clog2(TOC_DEPTH);
  localparam int CNT_W     = $clog2(TOC_DEPTH + 1);
  localparam int DIV_W     = 50;
  localparam int DVR_W     = 33;

  localparam logic [1:0] MODE_CBR  = 2'd0;
  localparam logic [1:0] MODE_XING = 2'd1;
  localparam logic [1:0] MODE_VBRI = 2'd2;

  localparam logic [2:0] REG_SEEK_MODE  = 3'd0;
  localparam logic [2:0] REG_DURATION   = 3'd1;
  localparam logic [2:0] REG_FIRST_OFS  = 3'd2;
  localparam logic [2:0] REG_AUDIO_SIZE = 3'd3;
  localparam logic [2:0] REG_FILE_SIZE  = 3'd4;
  localparam logic [2:0] REG_TOC_COUNT  = 3'd5;
  localparam logic [2:0] REG_VBRI_FPE   = 3'd6;
  localparam logic [2:0] REG_CBR_RATE   = 3'd7;

  localparam logic [31:0] XING_SCALE = 32'd25600;
  localparam logic [6:0]  XING_LAST  = 7'd99;
  localparam logic [8:0]  Q8_ONE     = 9'd256;

  typedef struct packed {
    logic [1:0]  seek_mode;
    logic [31:0] duration_ms;
    logic [31:0] first_frame_offset;
    logic [31:0] audio_bytes;
    logic [31:0] file_size;
    logic [7:0]  toc_count;
    logic [15:0] vbri_frames_per_entry;
    logic [31:0] cbr_bytes_per_ms_q16;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_C_MUL, ST_RES16, ST_X_MUL, ST_X_DIV, ST_X_DIVW, ST_X_CHK,
    ST_X_RDA, ST_X_RDB, ST_X_INT, ST_X_MUL2, ST_V_MUL1, ST_V_DIV1, ST_V_DIV1W,
    ST_V_I, ST_V_MUL2, ST_V_D, ST_V_MUL3, ST_V_DIV2, ST_V_DIV2W, ST_V_FRAC,
    ST_V_WALK, ST_V_WLAST, ST_V_MUL4, ST_V_DIV3, ST_V_DIV3W, ST_V_RES, ST_FIN
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_MUL_CBR, OP_RES_PROD16, OP_MUL_XQ, OP_DIV_DUR,
    OP_XSPLIT, OP_RD_A, OP_RD_B, OP_XINT, OP_MUL_XA, OP_MUL_SN, OP_SET_I,
    OP_MUL_ID, OP_SET_D, OP_MUL_DF, OP_DIV_FRAC, OP_FRAC, OP_WALK,
    OP_WALK_END, OP_MUL_BACK, OP_DIV_BACK, OP_RES_VBRI, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic x_early;
    logic walk_last;
    logic out_free;
  } dp_sts_t;

  // Saturate a widened sum to 32 bits.
  function automatic logic [31:0] sat32(input logic [DIV_W-1:0] v);
    return (v > DIV_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

endpackage

// ----- hw/rtl/mp3_seek_offset_mapper.sv -----
// Top level of the MP3 seek offset mapper: configuration registers and stream ports.
`timescale 1ns / 1ps
// The block turns a seek time in milliseconds into a byte offset in an MP3 stream.
// Input transfers on the s_ group carry a kind in s_tuser: 0 loads one table entry
// (no result), 1 asks for a seek offset (one result on the m_ group).
// Registers must be set by the user over the APB port while the block is idle, and
// the table loaded through the stream before any seek that reads it; the block
// itself does not enforce either. A table load is written in its accepting cycle.
// A Xing seek is dominated by one division. A VBRI seek runs three divisions through
// the shared bit-serial divider and a walk over the table RAM, one entry per cycle.
// Items are handled one at a time; s_tready is high only while the controller
// waits for a new item. A finished result sits in the output register, so the
// next item is taken while m_tvalid waits for m_tready; a later result then
// waits until that transfer completes.
// Reset returns the controller to idle, drops m_tvalid and restores the register
// defaults. Table contents are undefined until loaded.
module mp3_seek_offset_mapper (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // toc_index[6:0], toc_value[38:7], seek_ms[70:39], zero pad
  input  logic        s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // byte_offset[31:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mso_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  // Register writes land at the access-cycle edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.seek_mode             <= MODE_CBR;
      cfg.duration_ms           <= 32'd1;
      cfg.first_frame_offset    <= 32'd0;
      cfg.audio_bytes           <= 32'd0;
      cfg.file_size             <= 32'd0;
      cfg.toc_count             <= 8'd100;
      cfg.vbri_frames_per_entry <= 16'd1;
      cfg.cbr_bytes_per_ms_q16  <= 32'd0;
    end else if (cfg_we) begin
      case (paddr[4:2])
        REG_SEEK_MODE:  cfg.seek_mode             <= pwdata[1:0];
        REG_DURATION:   cfg.duration_ms           <= pwdata;
        REG_FIRST_OFS:  cfg.first_frame_offset    <= pwdata;
        REG_AUDIO_SIZE: cfg.audio_bytes           <= pwdata;
        REG_FILE_SIZE:  cfg.file_size             <= pwdata;
        REG_TOC_COUNT:  cfg.toc_count             <= pwdata[7:0];
        REG_VBRI_FPE:   cfg.vbri_frames_per_entry <= pwdata[15:0];
        REG_CBR_RATE:   cfg.cbr_bytes_per_ms_q16  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_SEEK_MODE:  prdata = 32'(cfg.seek_mode);
      REG_DURATION:   prdata = cfg.duration_ms;
      REG_FIRST_OFS:  prdata = cfg.first_frame_offset;
      REG_AUDIO_SIZE: prdata = cfg.audio_bytes;
      REG_FILE_SIZE:  prdata = cfg.file_size;
      REG_TOC_COUNT:  prdata = 32'(cfg.toc_count);
      REG_VBRI_FPE:   prdata = 32'(cfg.vbri_frames_per_entry);
      REG_CBR_RATE:   prdata = cfg.cbr_bytes_per_ms_q16;
      default:        prdata = 32'd0;
    endcase
  end

  mso_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_req    (s_tuser),
    .seek_mode (cfg.seek_mode),
    .sts       (sts),
    .in_ready  (s_tready),
    .cmd       (cmd)
  );

  mso_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .req_type  (s_tuser),
    .toc_index (s_tdata[6:0]),
    .toc_value (s_tdata[38:7]),
    .seek_ms   (s_tdata[70:39]),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_data  (m_tdata)
  );

endmodule

// ----- hw/rtl/mso_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mso_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/mso_div.sv -----
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module mso_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [mso_pkg::DIV_W-1:0]   dividend,
  input  logic [mso_pkg::DVR_W-1:0]   divisor,
  output logic                        busy,
  output logic                        done,
  output logic [mso_pkg::DIV_W-1:0]   quot
);
  import mso_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic [DVR_W-1:0] dvr;
  logic [DVR_W-1:0] rem;
  logic [CW-1:0]    cnt;
  logic [DVR_W:0]   shifted;
  logic [DVR_W:0]   rem_next;
  logic             ge;

  always_comb begin
    shifted  = {rem, quot[DIV_W-1]};
    ge       = shifted >= {1'b0, dvr};
    rem_next = ge ? (shifted - {1'b0, dvr}) : shifted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      dvr  <= divisor;
      rem  <= '0;
    end else if (busy) begin
      quot <= {quot[DIV_W-2:0], ge};
      rem  <= rem_next[DVR_W-1:0];
    end
  end

endmodule

// ----- hw/rtl/mso_dp.sv -----
// Datapath: operand registers, shared multiplier, divider, table RAM, result register.
`timescale 1ns / 1ps
module mso_dp (
  input  logic              clk,
  input  logic              rst,
  input  mso_pkg::cfg_t     cfg,
  input  mso_pkg::dp_cmd_t  cmd,
  output mso_pkg::dp_sts_t  sts,
  input  logic              req_type,
  input  logic [6:0]        toc_index,
  input  logic [31:0]       toc_value,
  input  logic [31:0]       seek_ms,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [31:0]       out_data
);
  import mso_pkg::*;

  logic [31:0]       dur_eff;
  logic [15:0]       fpe_eff;
  logic [CNT_W-1:0]  cnt_ext;
  logic [CNT_W-1:0]  n_eff;

  logic [31:0]       seek_r;
  logic [31:0]       s_r;
  logic [63:0]       prod;
  logic [39:0]       sn_r;
  logic [6:0]        a_r;
  logic [7:0]        f_r;
  logic [7:0]        fa_r;
  logic [16:0]       x_r;
  logic [CNT_W-1:0]  i_r;
  logic [CNT_W-1:0]  k_r;
  logic [32:0]       d_r;
  logic [16:0]       frac_r;
  logic [39:0]       acc;
  logic [31:0]       last_r;
  logic [31:0]       res;

  logic [32:0]       mul_a;
  logic [31:0]       mul_b;
  logic [64:0]       mul_full;

  logic              div_start;
  logic [DIV_W-1:0]  div_dvd;
  logic [DVR_W-1:0]  div_dvr;
  logic              div_busy;
  logic              div_done;
  logic [DIV_W-1:0]  quot;

  logic              ram_we;
  logic              ram_re;
  logic [TOC_AW-1:0] ram_raddr;
  logic [31:0]       rdata;

  logic [DIV_W-1:0]  qm;
  logic [8:0]        fb;
  logic signed [19:0] x_s;
  logic [39:0]       vb_sum;

  assign dur_eff = (cfg.duration_ms == 32'd0) ? 32'd1 : cfg.duration_ms;
  assign fpe_eff = (cfg.vbri_frames_per_entry == 16'd0) ? 16'd1 : cfg.vbri_frames_per_entry;
  assign cnt_ext = CNT_W'(cfg.toc_count);
  always_comb begin
    if (cnt_ext == '0) begin
      n_eff = CNT_W'(1);
    end else if (cnt_ext > CNT_W'(TOC_DEPTH)) begin
      n_eff = CNT_W'(TOC_DEPTH);
    end else begin
      n_eff = cnt_ext;
    end
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_CBR:  begin mul_a = 33'(seek_r); mul_b = cfg.cbr_bytes_per_ms_q16; end
      OP_MUL_XQ:   begin mul_a = 33'(seek_r); mul_b = XING_SCALE; end
      OP_MUL_XA:   begin mul_a = 33'(x_r);    mul_b = cfg.audio_bytes; end
      OP_MUL_SN:   begin mul_a = 33'(s_r);    mul_b = 32'(n_eff); end
      OP_MUL_ID:   begin mul_a = 33'(i_r);    mul_b = dur_eff; end
      OP_MUL_DF:   begin mul_a = d_r;         mul_b = 32'(fpe_eff); end
      OP_MUL_BACK: begin mul_a = 33'(last_r); mul_b = 32'(frac_r); end
      default:     begin mul_a = '0;          mul_b = '0; end
    endcase
  end
  assign mul_full = mul_a * mul_b;

  // Divider operand selection.
  always_comb begin
    div_start = 1'b0;
    div_dvd   = prod[DIV_W-1:0];
    div_dvr   = DVR_W'(dur_eff);
    case (cmd.op)
      OP_DIV_DUR: begin
        div_start = 1'b1;
      end
      OP_DIV_FRAC: begin
        div_start = 1'b1;
        div_dvd   = DIV_W'({prod[48:0], 1'b0}) + DIV_W'(dur_eff);
        div_dvr   = {dur_eff, 1'b0};
      end
      OP_DIV_BACK: begin
        div_start = 1'b1;
        div_dvr   = DVR_W'(fpe_eff);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  mso_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvr),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (quot)
  );

  // Table RAM ports.
  assign ram_we = (cmd.op == OP_ACCEPT) && !req_type && (int'(toc_index) < TOC_DEPTH);
  always_comb begin
    ram_re    = 1'b1;
    ram_raddr = k_r[TOC_AW-1:0];
    case (cmd.op)
      OP_RD_A: ram_raddr = TOC_AW'(a_r);
      OP_RD_B: ram_raddr = TOC_AW'(a_r + 7'd1);
      OP_WALK: ram_raddr = k_r[TOC_AW-1:0];
      default: ram_re    = 1'b0;
    endcase
  end

  mso_ram #(.WIDTH(32), .DEPTH(TOC_DEPTH)) u_toc (
    .clk   (clk),
    .we    (ram_we),
    .waddr (TOC_AW'(toc_index)),
    .wdata (toc_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // Xing helpers: Q8 percent minus one, and the interpolation between two entries.
  assign qm = quot - DIV_W'(Q8_ONE);
  assign fb = (a_r < XING_LAST) ? {1'b0, rdata[7:0]} : Q8_ONE;
  assign x_s = $signed({4'b0, fa_r, 8'b0})
             + ($signed({11'b0, fb}) - $signed({12'b0, fa_r})) * $signed({12'b0, f_r});
  assign vb_sum = (acc >= quot[39:0] && quot[DIV_W-1:40] == '0) ? (acc - quot[39:0]) : 40'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_r <= '0;
      i_r <= '0;
    end else begin
      case (cmd.op)
        OP_SET_I: begin
          i_r <= (quot >= DIV_W'(n_eff)) ? n_eff : (quot[CNT_W-1:0] + 1'b1);
          k_r <= '0;
        end
        OP_WALK:  k_r <= k_r + 1'b1;
        default:  k_r <= k_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        seek_r <= seek_ms;
        s_r    <= (seek_ms > dur_eff) ? dur_eff : seek_ms;
      end
      OP_MUL_CBR, OP_MUL_XQ, OP_MUL_XA, OP_MUL_SN, OP_MUL_ID, OP_MUL_DF, OP_MUL_BACK: begin
        prod <= mul_full[63:0];
      end
      OP_RES_PROD16: res <= sat32(DIV_W'(cfg.first_frame_offset) + DIV_W'(prod[63:16]));
      OP_DIV_DUR:    sn_r <= prod[39:0];
      OP_XSPLIT: begin
        a_r <= qm[14:8];
        f_r <= qm[7:0];
        res <= (quot < DIV_W'(2 * Q8_ONE)) ? cfg.first_frame_offset : cfg.file_size;
      end
      OP_RD_B:     fa_r <= rdata[7:0];
      OP_XINT:     x_r  <= x_s[16:0];
      OP_SET_D:    d_r  <= 33'(prod[40:0] - {1'b0, sn_r});
      OP_FRAC: begin
        frac_r <= quot[16:0];
        acc    <= '0;
      end
      OP_WALK: begin
        if (k_r != '0) begin
          acc <= acc + 40'(rdata);
        end
      end
      OP_WALK_END: begin
        acc    <= acc + 40'(rdata);
        last_r <= rdata;
      end
      OP_RES_VBRI: res <= sat32(DIV_W'(cfg.first_frame_offset) + DIV_W'(vb_sum));
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      out_data <= res;
    end
  end

  always_comb begin
    sts.div_busy  = div_busy;
    sts.div_done  = div_done;
    sts.x_early   = (quot < DIV_W'(2 * Q8_ONE))
                 || (quot >= DIV_W'(XING_SCALE) + DIV_W'(Q8_ONE));
    sts.walk_last = (k_r == i_r - 1'b1);
    sts.out_free  = !out_valid || out_ready;
  end

  // The table walk never reads past the clamped entry count.
  a_walk_bound: assert property (@(posedge clk) disable iff (rst) k_r <= i_r)
    else $error("table walk ran past its entry count");

endmodule

// ----- hw/rtl/mso_ctrl.sv -----
// Controller state machine that sequences the datapath for each item.
`timescale 1ns / 1ps
module mso_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_req,
  input  logic [1:0]        seek_mode,
  input  mso_pkg::dp_sts_t  sts,
  output logic              in_ready,
  output mso_pkg::dp_cmd_t  cmd
);
  import mso_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd.op     = OP_NONE;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_ACCEPT;
          if (in_req) begin
            if (seek_mode == MODE_XING) begin
              state_next = ST_X_MUL;
            end else if (seek_mode == MODE_VBRI) begin
              state_next = ST_V_MUL1;
            end else begin
              state_next = ST_C_MUL;
            end
          end
        end
      end
      ST_C_MUL:   begin cmd.op = OP_MUL_CBR;    state_next = ST_RES16; end
      ST_RES16:   begin cmd.op = OP_RES_PROD16; state_next = ST_FIN; end
      ST_X_MUL:   begin cmd.op = OP_MUL_XQ;     state_next = ST_X_DIV; end
      ST_X_DIV:   begin cmd.op = OP_DIV_DUR;    state_next = ST_X_DIVW; end
      ST_X_DIVW: begin
        if (sts.div_done) begin
          state_next = ST_X_CHK;
        end
      end
      ST_X_CHK: begin
        cmd.op     = OP_XSPLIT;
        state_next = sts.x_early ? ST_FIN : ST_X_RDA;
      end
      ST_X_RDA:   begin cmd.op = OP_RD_A;       state_next = ST_X_RDB; end
      ST_X_RDB:   begin cmd.op = OP_RD_B;       state_next = ST_X_INT; end
      ST_X_INT:   begin cmd.op = OP_XINT;       state_next = ST_X_MUL2; end
      ST_X_MUL2:  begin cmd.op = OP_MUL_XA;     state_next = ST_RES16; end
      ST_V_MUL1:  begin cmd.op = OP_MUL_SN;     state_next = ST_V_DIV1; end
      ST_V_DIV1:  begin cmd.op = OP_DIV_DUR;    state_next = ST_V_DIV1W; end
      ST_V_DIV1W: begin
        if (sts.div_done) begin
          state_next = ST_V_I;
        end
      end
      ST_V_I:     begin cmd.op = OP_SET_I;      state_next = ST_V_MUL2; end
      ST_V_MUL2:  begin cmd.op = OP_MUL_ID;     state_next = ST_V_D; end
      ST_V_D:     begin cmd.op = OP_SET_D;      state_next = ST_V_MUL3; end
      ST_V_MUL3:  begin cmd.op = OP_MUL_DF;     state_next = ST_V_DIV2; end
      ST_V_DIV2:  begin cmd.op = OP_DIV_FRAC;   state_next = ST_V_DIV2W; end
      ST_V_DIV2W: begin
        if (sts.div_done) begin
          state_next = ST_V_FRAC;
        end
      end
      ST_V_FRAC:  begin cmd.op = OP_FRAC;       state_next = ST_V_WALK; end
      ST_V_WALK: begin
        cmd.op = OP_WALK;
        if (sts.walk_last) begin
          state_next = ST_V_WLAST;
        end
      end
      ST_V_WLAST: begin cmd.op = OP_WALK_END;   state_next = ST_V_MUL4; end
      ST_V_MUL4:  begin cmd.op = OP_MUL_BACK;   state_next = ST_V_DIV3; end
      ST_V_DIV3:  begin cmd.op = OP_DIV_BACK;   state_next = ST_V_DIV3W; end
      ST_V_DIV3W: begin
        if (sts.div_done) begin
          state_next = ST_V_RES;
        end
      end
      ST_V_RES:   begin cmd.op = OP_RES_VBRI;   state_next = ST_FIN; end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.op     = OP_OUT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Waiting on the divider only makes sense while it is running or just finished.
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    (state == ST_X_DIVW || state == ST_V_DIV1W || state == ST_V_DIV2W ||
     state == ST_V_DIV3W) |-> (sts.div_busy || sts.div_done))
    else $error("controller waits on an idle divider");

  // A result is only loaded when the output register can take it.
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_OUT) |-> sts.out_free)
    else $error("result overwrote a pending transfer");

  // A table load finishes in its accepting cycle.
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_valid && !in_req) |=> (state == ST_IDLE))
    else $error("table load did not return to idle");

endmodule

// ----- test/mp3_seek_offset_mapper_tb.sv -----
// Self-checking testbench of the MP3 seek offset mapper.
`timescale 1ns / 1ps
// The table is filled once after reset, so no seek ever reads an unloaded entry.
// The run then goes through constant bitrate, Xing and VBRI settings, the extremes
// among them. Each phase holds a few directed seeks followed by random loads and
// seeks. A predictor in this file computes each expected byte offset when the
// request transfer is accepted. A monitor compares every result transfer with
// the oldest expected offset.
module mp3_seek_offset_mapper_tb;
  import mso_pkg::*;

  localparam bit         KIND_LOAD    = 1'b0;
  localparam bit         KIND_SEEK    = 1'b1;
  localparam logic [1:0] MODE_ALT_CBR = 2'd3;  // the unused mode code acts as CBR
  localparam int         SETTLE       = 400;   // longer than the slowest VBRI seek

  typedef struct {
    bit        kind;
    bit [6:0]  idx;
    bit [31:0] val;
    bit [31:0] ms;
  } seek_req_t;

  logic        clk, rst;
  logic        s_tvalid, s_tready, s_tuser;
  logic [71:0] s_tdata;   // toc_index[6:0], toc_value[38:7], seek_ms[70:39], zero pad
  logic        m_tvalid, m_tready;
  logic [31:0] m_tdata;   // byte_offset[31:0]
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;

  mp3_seek_offset_mapper u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Local copy of the register file and the table, kept in step with the block.
  cfg_t      regs;
  bit [31:0] toc_copy [TOC_DEPTH];

  seek_req_t pending_reqs [$];
  bit [31:0] offsets_due [$];
  seek_req_t cur_req;
  bit        holding, taken, calm;
  int        mismatches, loads_done, seeks_done, offsets_checked;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Adds with saturation at the 32-bit limit.
  function automatic bit [31:0] sat_sum(bit [63:0] base, bit [63:0] extra);
    bit [63:0] total;
    total = base + extra;
    return (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
  endfunction

  // Expected byte offset of a seek under the current registers and table.
  function automatic bit [31:0] predict_offset(bit [31:0] ms);
    bit [63:0] dur, q, a, f, n, fpe, s, i, sum, d, frac, back;
    longint    fa, fb, x;
    dur = (regs.duration_ms == 0) ? 64'd1 : 64'(regs.duration_ms);
    case (regs.seek_mode)
      MODE_XING: begin
        q = 64'(ms) * 64'd25600 / dur;
        if (q < 64'd512) return regs.first_frame_offset;
        q = q - 64'd256;
        if (q >= 64'd25600) return regs.file_size;
        a = q >> 8;
        f = q & 64'd255;
        fa = longint'(toc_copy[a] & 32'hFF);
        fb = (a < 64'd99) ? longint'(toc_copy[a + 1] & 32'hFF) : longint'(256);
        x = fa * 256 + (fb - fa) * longint'(f);
        return sat_sum(64'(regs.first_frame_offset),
                       (64'(x) * 64'(regs.audio_bytes)) >> 16);
      end
      MODE_VBRI: begin
        n = (regs.toc_count == 0) ? 64'd1 : 64'(regs.toc_count);
        if (n > 64'(TOC_DEPTH)) n = 64'(TOC_DEPTH);
        fpe = (regs.vbri_frames_per_entry == 0) ? 64'd1 : 64'(regs.vbri_frames_per_entry);
        s = (64'(ms) > dur) ? dur : 64'(ms);
        i = s * n / dur + 64'd1;
        if (i > n) i = n;
        sum = 64'd0;
        for (int k = 0; k < i; k++) sum += 64'(toc_copy[k]);
        d = i * dur - s * n;
        frac = (64'd2 * d * fpe + dur) / (64'd2 * dur);
        back = 64'(toc_copy[i - 1]) * frac / fpe;
        sum = (sum >= back) ? sum - back : 64'd0;
        return sat_sum(64'(regs.first_frame_offset), sum);
      end
      default: begin
        return sat_sum(64'(regs.first_frame_offset),
                       (64'(ms) * 64'(regs.cbr_bytes_per_ms_q16)) >> 16);
      end
    endcase
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  // Request side: an accepted transfer updates the table copy or queues an offset.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      if (cur_req.kind == KIND_LOAD) begin
        toc_copy[cur_req.idx] = cur_req.val;
        loads_done++;
      end else begin
        offsets_due.push_back(predict_offset(cur_req.ms));
        seeks_done++;
      end
      taken = 1'b1;
    end
  end

  // Driver: a presented request stays valid until it is taken; gaps fall only between.
  always @(negedge clk) begin
    if (!rst) begin
      if (taken) begin
        taken = 1'b0;
        holding = 1'b0;
      end
      if (!holding && pending_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= 10)) begin
        cur_req = pending_reqs.pop_front();
        holding = 1'b1;
      end
      s_tvalid <= holding;
      s_tuser  <= cur_req.kind;
      s_tdata  <= {1'b0, cur_req.ms, cur_req.val, cur_req.idx};
      m_tready <= calm || ($urandom_range(0, 99) >= 10);
    end
  end

  // Monitor: every result transfer is matched against the oldest expected offset.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (offsets_due.size() == 0) begin
        report_mismatch($sformatf("unexpected offset %h", m_tdata));
      end else begin
        if (m_tdata !== offsets_due[0])
          report_mismatch($sformatf("byte_offset %h, expected %h", m_tdata, offsets_due[0]));
        void'(offsets_due.pop_front());
        offsets_checked++;
      end
    end
  end

  task automatic reg_write(logic [2:0] which, logic [31:0] value);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {which, 2'b00}; pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    case (which)
      REG_SEEK_MODE:  regs.seek_mode = value[1:0];
      REG_DURATION:   regs.duration_ms = value;
      REG_FIRST_OFS:  regs.first_frame_offset = value;
      REG_AUDIO_SIZE: regs.audio_bytes = value;
      REG_FILE_SIZE:  regs.file_size = value;
      REG_TOC_COUNT:  regs.toc_count = value[7:0];
      REG_VBRI_FPE:   regs.vbri_frames_per_entry = value[15:0];
      default:        regs.cbr_bytes_per_ms_q16 = value;
    endcase
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic program_regs(logic [1:0] mode, logic [31:0] dur, logic [31:0] ffo,
                              logic [31:0] ab, logic [31:0] fs, logic [7:0] cnt,
                              logic [15:0] fpe, logic [31:0] rate);
    reg_write(REG_SEEK_MODE, {30'd0, mode});
    reg_write(REG_DURATION, dur);
    reg_write(REG_FIRST_OFS, ffo);
    reg_write(REG_AUDIO_SIZE, ab);
    reg_write(REG_FILE_SIZE, fs);
    reg_write(REG_TOC_COUNT, {24'd0, cnt});
    reg_write(REG_VBRI_FPE, {16'd0, fpe});
    reg_write(REG_CBR_RATE, rate);
  endtask

  // Waits until every queued request has gone and every offset has arrived, then
  // lets the block finish any trailing work before the registers change.
  task automatic wait_idle();
    while (pending_reqs.size() > 0 || holding || offsets_due.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic queue_req(bit kind, bit [6:0] idx, bit [31:0] val, bit [31:0] ms);
    seek_req_t r;
    r.kind = kind; r.idx = idx; r.val = val; r.ms = ms;
    pending_reqs.push_back(r);
  endtask

  function automatic bit [31:0] random_entry();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  // Mostly times within a little beyond the duration, with the ends and wild values mixed in.
  function automatic bit [31:0] random_ms(bit [31:0] dur);
    bit [63:0] span, pick;
    span = 64'(dur) + 64'(dur) / 8 + 1;
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return dur;
      2: return 32'hFFFF_FFFF;
      3: return $urandom;
      default: begin
        pick = {$urandom, $urandom} % span;
        return (pick > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : pick[31:0];
      end
    endcase
  endfunction

  initial begin
    bit [31:0] d;
    rst = 1'b1;
    s_tvalid = 1'b0; s_tuser = 1'b0; s_tdata = '0; m_tready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    holding = 1'b0; taken = 1'b0; calm = 1'b0;
    mismatches = 0; loads_done = 0; seeks_done = 0; offsets_checked = 0;
    cur_req = '{default: 0};
    regs = '{seek_mode: MODE_CBR, duration_ms: 32'd1, first_frame_offset: 32'd0,
             audio_bytes: 32'd0, file_size: 32'd0, toc_count: 8'd100,
             vbri_frames_per_entry: 16'd1, cbr_bytes_per_ms_q16: 32'd0};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int phase = 0; phase < 11; phase++) begin
      if (phase > 0) wait_idle();
      calm = (phase == 5);
      case (phase)
        1: program_regs(MODE_CBR, $urandom, $urandom, $urandom, $urandom, 8'd100,
                        16'd1, 32'hFFFF_FFFF);
        2: program_regs(MODE_ALT_CBR, $urandom, 32'hFFFF_FFF0, 0, 0, 8'd7, 16'd3, $urandom);
        3: program_regs(MODE_XING, $urandom_range(1000, 600000), $urandom_range(0, 65535),
                        $urandom, $urandom, 8'd100, 16'd1, $urandom);
        4: program_regs(MODE_XING, 32'd0, $urandom, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        8'd50, 16'd9, 0);
        5: program_regs(MODE_XING, 32'hFFFF_FFFF, 32'hFFFF_FF00, $urandom, 0,
                        8'd1, 16'd2, 0);
        6: program_regs(MODE_VBRI, $urandom_range(1000, 600000), $urandom_range(0, 4096),
                        0, 0, 8'd100, 16'($urandom_range(1, 2000)), 0);
        7: program_regs(MODE_VBRI, 32'd1, $urandom, 0, 0, 8'd0, 16'd0, 0);
        8: program_regs(MODE_VBRI, 32'hFFFF_FFFF, 32'hFFFF_FF00, 0, 0, 8'd255,
                        16'hFFFF, 0);
        9: program_regs(MODE_VBRI, $urandom, $urandom, 0, 0, 8'd1, 16'($urandom), 0);
        10: program_regs(MODE_VBRI, $urandom_range(1, 200), 0, 0, 0, 8'd128,
                         16'($urandom_range(1, 16)), 0);
        default: ;
      endcase
      d = regs.duration_ms;

      // The whole table is loaded before the first seek, extremes at the ends.
      if (phase == 0) begin
        for (int k = 0; k < TOC_DEPTH; k++)
          queue_req(KIND_LOAD, k[6:0], (k == 0) ? 32'd0 :
                    (k == TOC_DEPTH - 1) ? 32'hFFFF_FFFF : random_entry(), $urandom);
      end

      // Directed seeks at the start, just past it, at the end, just before it and beyond it.
      queue_req(KIND_SEEK, 7'($urandom), $urandom, 32'd0);
      queue_req(KIND_SEEK, 7'($urandom), $urandom, 32'd1);
      queue_req(KIND_SEEK, 7'($urandom), $urandom, d);
      queue_req(KIND_SEEK, 7'($urandom), $urandom, (d == 0) ? 32'd0 : d - 1);
      queue_req(KIND_SEEK, 7'($urandom), $urandom, 32'hFFFF_FFFF);

      for (int k = 0; k < 90; k++) begin
        if ($urandom_range(0, 99) < 20)
          queue_req(KIND_LOAD, 7'($urandom), random_entry(), $urandom);
        else
          queue_req(KIND_SEEK, 7'($urandom), $urandom, random_ms(d));
      end
    end

    wait_idle();
    $display("Covered %0d table loads and %0d seeks over CBR, Xing and VBRI settings;",
             loads_done, seeks_done);
    $display("%0d offsets compared, %0d mismatches.", offsets_checked, mismatches);
    if (mismatches == 0 && offsets_due.size() == 0) begin
      $display("mp3_seek_offset_mapper regression: pass");
    end else begin
      $display("mp3_seek_offset_mapper regression: fail");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #40_000_000;
    $display("Timeout with %0d offsets still expected.", offsets_due.size());
    $display("mp3_seek_offset_mapper regression: fail");
    $finish;
  end

endmodule
